### src/rgbh_pkg.sv
// Shared types, widths and constants of the RGB octant histogram unit.
package rgbh_pkg;

  localparam int CH_W     = 8;
  localparam int BIN_W    = 3;
  localparam int NUM_BINS = 8;
  localparam int GRAY_W   = 8;
  localparam int COUNT_W  = 23;
  localparam int CFG_W    = 13;

  localparam logic [GRAY_W-1:0]  GRAY_MAX  = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // Configuration port geometry: two 32-bit registers at byte offsets 0 and 4.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // One saturation check followed by one quotient bit per step.
  localparam int DIV_STEPS = GRAY_W + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic pix_accept;
    logic frame_end;
    logic clear_bin;
  } acc_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sat_step;
  } div_ctrl_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [CH_W-1:0] r,
                                               input logic [CH_W-1:0] g,
                                               input logic [CH_W-1:0] b);
    bin_of = {r[CH_W-1], g[CH_W-1], b[CH_W-1]};
  endfunction

endpackage

### src/rgbh_apb_regs.sv
// APB-style configuration registers holding the frame dimensions.
module rgbh_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rgbh_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rgbh_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rgbh_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [rgbh_pkg::CFG_W-1:0]      frame_width,
  output logic [rgbh_pkg::CFG_W-1:0]      frame_height
);
  import rgbh_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

endmodule

### src/rgbh_pixel_acc.sv
// Raster position tracking, crop window test and the eight bin counters.
module rgbh_pixel_acc #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rgbh_pkg::acc_ctrl_t               ctrl,
  input  logic [rgbh_pkg::CH_W-1:0]         red,
  input  logic [rgbh_pkg::CH_W-1:0]         green,
  input  logic [rgbh_pkg::CH_W-1:0]         blue,
  input  logic [rgbh_pkg::CFG_W-1:0]        frame_width,
  input  logic [rgbh_pkg::CFG_W-1:0]        frame_height,
  input  logic [rgbh_pkg::BIN_W-1:0]        rd_sel,
  output logic [rgbh_pkg::COUNT_W-1:0]      rd_count,
  output logic [$clog2(MAX_DIM+1)-2:0]      crop_w,
  output logic [$clog2(MAX_DIM+1)-2:0]      crop_h
);
  import rgbh_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int POS_W = $clog2(MAX_DIM);
  localparam int EXT_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  // Out-of-range dimensions are pinned to the nearest legal value.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    if (ve < EXT_W'(2))            clamp_dim = DIM_W'(2);
    else if (ve > EXT_W'(MAX_DIM)) clamp_dim = DIM_W'(MAX_DIM);
    else                           clamp_dim = DIM_W'(ve);
  endfunction

  logic [COUNT_W-1:0] counts [NUM_BINS];
  logic [POS_W-1:0]   row;
  logic [POS_W-1:0]   col;

  logic [DIM_W-1:0] w_c, h_c;
  logic [DIM_W-1:0] c0, c_end, r0, r_end;
  logic [DIM_W-1:0] col_inc;
  logic             in_crop;
  logic [BIN_W-1:0] bin;

  assign w_c    = clamp_dim(frame_width);
  assign h_c    = clamp_dim(frame_height);
  assign crop_w = w_c[DIM_W-1:1];
  assign crop_h = h_c[DIM_W-1:1];

  // The window starts half a crop before the frame center.
  assign c0    = DIM_W'(crop_w) - DIM_W'(crop_w >> 1);
  assign r0    = DIM_W'(crop_h) - DIM_W'(crop_h >> 1);
  assign c_end = c0 + DIM_W'(crop_w);
  assign r_end = r0 + DIM_W'(crop_h);

  assign in_crop = (DIM_W'(row) >= r0) && (DIM_W'(row) < r_end) &&
                   (DIM_W'(col) >= c0) && (DIM_W'(col) < c_end);
  assign col_inc = DIM_W'(col) + DIM_W'(1);
  assign bin     = bin_of(red, green, blue);
  assign rd_count = counts[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      for (int i = 0; i < NUM_BINS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (ctrl.pix_accept) begin
        if (in_crop && counts[bin] != COUNT_MAX) begin
          counts[bin] <= counts[bin] + COUNT_W'(1);
        end
        if (ctrl.frame_end) begin
          row <= '0;
          col <= '0;
        end else if (col_inc >= w_c) begin
          col <= '0;
          if (row != POS_W'(MAX_DIM - 1)) begin
            row <= row + POS_W'(1);
          end
        end else begin
          col <= col_inc[POS_W-1:0];
        end
      end
      if (ctrl.clear_bin) begin
        counts[rd_sel] <= '0;
      end
    end
  end

endmodule

### src/rgbh_div_unit.sv
// Shared restoring divider: one compare and subtract per step, saturating at full scale.
module rgbh_div_unit #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 24
) (
  input  logic                       clk,
  input  rgbh_pkg::div_ctrl_t        ctrl,
  input  logic [NUM_W-1:0]           numer,
  input  logic [DEN_W-1:0]           denom,
  output logic [rgbh_pkg::GRAY_W-1:0] quot
);
  import rgbh_pkg::*;

  localparam int CMP_W = (NUM_W > DEN_W + GRAY_W) ? NUM_W : DEN_W + GRAY_W;

  logic [CMP_W-1:0]  rem;
  logic [CMP_W-1:0]  dsh;
  logic [GRAY_W-1:0] q;
  logic              sat;
  logic              ge;
  logic [CMP_W-1:0]  diff;

  assign ge   = rem >= dsh;
  assign diff = rem - dsh;
  assign quot = sat ? GRAY_MAX : q;

  // The first step tests the divisor shifted past the top quotient bit; a hit
  // means the quotient cannot fit and the result saturates.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= CMP_W'(numer);
      dsh <= CMP_W'(denom) << GRAY_W;
      q   <= '0;
      sat <= 1'b0;
    end else if (ctrl.step) begin
      dsh <= dsh >> 1;
      if (ctrl.sat_step) begin
        sat <= ge;
      end else begin
        q <= {q[GRAY_W-2:0], ge};
        if (ge) begin
          rem <= diff;
        end
      end
    end
  end

endmodule

### src/rgb_octant_histogram_unit.sv
// Top level of the RGB octant histogram unit: sequencer, result register and wiring.
//
// The unit takes an RGB frame in raster order, one pixel per transfer, and counts only
// the pixels inside the centered crop of half the frame width and half the frame height.
// Each counted pixel goes to one of eight bins chosen by the top bit of red, green and
// blue (bin = R*4 + G*2 + B). Pixels are accepted one per clock while busy is low. The
// transfer that carries frame_end raises busy, and the unit then scales every bin to
// count*255/crop_pixels with a single shared restoring divider. Each bin gets
// one load, nine compare-and-subtract steps of which the first detects saturation, and
// one emit step that registers the result. The eight results come out in bin order, each
// for exactly one cycle with result_valid high, and the eighth carries last_bin. The
// receiver cannot stall the results, so it must take each one in the cycle it is shown.
// The counters clear as they are read and the raster position clears at frame end, so
// the next frame may start as soon as busy drops. frame_width and frame_height are
// written through the APB-style port at byte offsets 0 and 4; values below 2 act as 2
// and values above MAX_DIM act as MAX_DIM. Registers should only be written between
// frames.
module rgb_octant_histogram_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [rgbh_pkg::CH_W-1:0]       red,
  input  logic [rgbh_pkg::CH_W-1:0]       green,
  input  logic [rgbh_pkg::CH_W-1:0]       blue,
  input  logic                            frame_end,
  output logic                            result_valid,
  output logic [rgbh_pkg::BIN_W-1:0]      bin_index,
  output logic [rgbh_pkg::GRAY_W-1:0]     gray_level,
  output logic                            last_bin,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rgbh_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rgbh_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rgbh_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import rgbh_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int HALF_W = DIM_W - 1;
  localparam int TOT_W  = 2 * HALF_W;
  localparam int NUM_W  = COUNT_W + GRAY_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state, state_next;
  logic [BIN_W-1:0]   bin_sel;
  logic [STEP_W-1:0]  step_cnt;
  logic [TOT_W-1:0]   total;

  logic [CFG_W-1:0]   cfg_width, cfg_height;
  logic [HALF_W-1:0]  crop_w, crop_h;
  logic [COUNT_W-1:0] rd_count;
  logic [NUM_W-1:0]   numer;
  logic [GRAY_W-1:0]  quot;
  logic               pix_accept;
  logic               last_sel;
  acc_ctrl_t          acc_ctrl;
  div_ctrl_t          div_ctrl;

  assign busy       = (state != ST_IDLE);
  assign pix_accept = start && !busy;
  assign last_sel   = (bin_sel == BIN_W'(NUM_BINS - 1));

  // count * 255 as a shift and subtract.
  assign numer = (NUM_W'(rd_count) << GRAY_W) - NUM_W'(rd_count);

  assign acc_ctrl.pix_accept = pix_accept;
  assign acc_ctrl.frame_end  = frame_end;
  assign acc_ctrl.clear_bin  = (state == ST_LOAD);

  assign div_ctrl.load     = (state == ST_LOAD);
  assign div_ctrl.step     = (state == ST_STEP);
  assign div_ctrl.sat_step = (step_cnt == '0);

  rgbh_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (cfg_width),
    .frame_height (cfg_height)
  );

  rgbh_pixel_acc #(
    .MAX_DIM (MAX_DIM)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (acc_ctrl),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .frame_width  (cfg_width),
    .frame_height (cfg_height),
    .rd_sel       (bin_sel),
    .rd_count     (rd_count),
    .crop_w       (crop_w),
    .crop_h       (crop_h)
  );

  rgbh_div_unit #(
    .NUM_W (NUM_W),
    .DEN_W (TOT_W)
  ) u_div (
    .clk   (clk),
    .ctrl  (div_ctrl),
    .numer (numer),
    .denom (total),
    .quot  (quot)
  );

  // Sequencer: walks the bins, giving each one load, the divider steps and an emit.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (pix_accept && frame_end) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_STEP;
      ST_STEP: if (step_cnt == STEP_W'(DIV_STEPS - 1)) state_next = ST_EMIT;
      ST_EMIT: state_next = last_sel ? ST_IDLE : ST_LOAD;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bin_sel      <= '0;
      step_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_EMIT);
      case (state)
        ST_IDLE: bin_sel <= '0;
        ST_LOAD: step_cnt <= '0;
        ST_STEP: step_cnt <= step_cnt + STEP_W'(1);
        ST_EMIT: bin_sel <= bin_sel + BIN_W'(1);
        default: ;
      endcase
    end
  end

  // Crop pixel count is captured with the frame's last pixel, while the
  // dimensions are the ones that frame used.
  always_ff @(posedge clk) begin
    if (pix_accept && frame_end) begin
      total <= TOT_W'(crop_w) * TOT_W'(crop_h);
    end
  end

  // Result register; the strobe above marks the single cycle it is valid.
  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      bin_index  <= bin_sel;
      gray_level <= quot;
      last_bin   <= last_sel;
    end
  end

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_last_is_bin7: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_bin == (bin_index == BIN_W'(NUM_BINS - 1))))
    else $error("last_bin does not match the final bin");

  a_frame_end_starts: assert property (@(posedge clk) disable iff (rst)
    (pix_accept && frame_end) |=> (state == ST_LOAD && bin_sel == '0))
    else $error("frame end did not start the scaling pass at bin zero");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == ST_EMIT && bin_index == $past(bin_sel)))
    else $error("result strobe without an emit step");
`endif

endmodule
